### rtl/mi3_pkg.sv
// Shared widths, types and register codes for the 3x3 matrix inverse.
// No dependencies; every rtl file refers to it by scoped names.
package mi3_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_ELEM  = 9;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ADJ_W     = PROD_W + 1;
    localparam int DET_W     = 3 * ELEM_W + 2;
    localparam int DETQ_W    = DET_W - 2 * FRAC_BITS;
    localparam int MAG_W     = DET_W - 1;
    localparam int AMAG_W    = PROD_W;
    localparam int QUO_W     = ELEM_W + 1;
    localparam int CMP_W     = MAG_W + QUO_W - 1;
    localparam int THR_W     = 31;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ADJ_W-1:0]  adj_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic signed [DETQ_W-1:0] detq_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [AMAG_W-1:0]        amag_t;
    typedef logic [THR_W-1:0]         thr_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    localparam logic REG_DET_THRESHOLD = 1'b0;

    typedef struct packed {
        elem_t [NUM_ELEM-1:0] r;
        elem_t                det;
        logic                 sing;
    } result_t;

endpackage

### rtl/mi3_adj.sv
// Adjugate stages: eighteen 32x32 products, then nine differences.
// Depends on mi3_pkg.
module mi3_adj (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  mi3_pkg::elem_t [mi3_pkg::NUM_ELEM-1:0] in_elem,
    output logic                                   out_valid,
    output mi3_pkg::adj_t  [mi3_pkg::NUM_ELEM-1:0] out_adj,
    output mi3_pkg::elem_t [2:0]                   out_row1
);

    localparam int NPROD = 2 * mi3_pkg::NUM_ELEM;
    localparam int MUL_A [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int MUL_B [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    mi3_pkg::prod_t prod_reg [NPROD];
    mi3_pkg::elem_t row1_reg [2][3];
    mi3_pkg::adj_t  adj_reg  [mi3_pkg::NUM_ELEM];
    logic           vld_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPROD; i++)
            begin
                prod_reg[i] <= mi3_pkg::prod_t'(in_elem[MUL_A[i]] * in_elem[MUL_B[i]]);
            end
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
            begin
                adj_reg[i] <= mi3_pkg::adj_t'(prod_reg[2*i]) - mi3_pkg::adj_t'(prod_reg[2*i+1]);
            end
            for (int j = 0; j < 3; j++)
            begin
                row1_reg[0][j] <= in_elem[j];
                row1_reg[1][j] <= row1_reg[0][j];
            end
        end
    end

    always_comb
    begin
        out_valid = vld_reg[1];
        for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
        begin
            out_adj[i] = adj_reg[i];
        end
        for (int j = 0; j < 3; j++)
        begin
            out_row1[j] = row1_reg[1][j];
        end
    end

endmodule

### rtl/mi3_det.sv
// Determinant by cofactor expansion along row 1, split into 33x32 partial products.
// Depends on mi3_pkg.
module mi3_det (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  mi3_pkg::adj_t  [mi3_pkg::NUM_ELEM-1:0] in_adj,
    input  mi3_pkg::elem_t [2:0]                   in_row1,
    output logic                                   out_valid,
    output mi3_pkg::adj_t  [mi3_pkg::NUM_ELEM-1:0] out_adj,
    output mi3_pkg::det_t                          out_det
);

    localparam int LO_W = mi3_pkg::ELEM_W;
    localparam int PP_W = mi3_pkg::ADJ_W;

    logic signed [PP_W-1:0] plo_reg [3];
    logic signed [PP_W-1:0] phi_reg [3];
    mi3_pkg::det_t          term_reg [3];
    mi3_pkg::det_t          det_reg;
    mi3_pkg::adj_t          adj_reg [3][mi3_pkg::NUM_ELEM];
    logic                   vld_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= PP_W'(signed'({1'b0, in_adj[3*j][LO_W-1:0]}) * in_row1[j]);
                phi_reg[j] <= PP_W'(signed'(in_adj[3*j][mi3_pkg::ADJ_W-1:LO_W]) * in_row1[j]);
                term_reg[j] <= (mi3_pkg::det_t'(phi_reg[j]) <<< LO_W)
                             + mi3_pkg::det_t'(plo_reg[j]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
            begin
                adj_reg[0][i] <= in_adj[i];
                adj_reg[1][i] <= adj_reg[0][i];
                adj_reg[2][i] <= adj_reg[1][i];
            end
        end
    end

    always_comb
    begin
        out_valid = vld_reg[2];
        out_det   = det_reg;
        for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
        begin
            out_adj[i] = adj_reg[2][i];
        end
    end

endmodule

### rtl/mi3_prep.sv
// Determinant rounding, singular test and divider operand setup.
// Depends on mi3_pkg.
module mi3_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  mi3_pkg::adj_t  [mi3_pkg::NUM_ELEM-1:0] in_adj,
    input  mi3_pkg::det_t                          in_det,
    input  mi3_pkg::thr_t                          det_threshold,
    output logic                                   out_valid,
    output logic                                   out_sing,
    output mi3_pkg::elem_t                         out_det,
    output logic           [mi3_pkg::NUM_ELEM-1:0] out_neg,
    output mi3_pkg::mag_t  [mi3_pkg::NUM_ELEM-1:0] out_num,
    output mi3_pkg::mag_t                          out_den
);

    localparam int DQ_W = mi3_pkg::DETQ_W;
    localparam int EW   = mi3_pkg::ELEM_W;
    localparam mi3_pkg::det_t HALF = mi3_pkg::det_t'(1) <<< (2 * mi3_pkg::FRAC_BITS - 1);

    // stage 6
    mi3_pkg::detq_t detq_reg;
    mi3_pkg::mag_t  absd_reg;
    mi3_pkg::amag_t absadj_reg [mi3_pkg::NUM_ELEM];
    logic [mi3_pkg::NUM_ELEM-1:0] neg6_reg;
    // stage 7
    logic           sing_reg;
    mi3_pkg::elem_t dsat_reg;
    logic [mi3_pkg::NUM_ELEM-1:0] neg7_reg;
    mi3_pkg::mag_t  num_reg [mi3_pkg::NUM_ELEM];
    mi3_pkg::mag_t  den_reg;
    logic           vld_reg [2];

    logic [DQ_W-1:0]    dq_mag;
    logic [DQ_W-EW:0]   dq_hi;
    logic               dq_fits;
    logic               sing_next;
    mi3_pkg::elem_t     dsat_next;

    always_comb
    begin
        dq_mag    = detq_reg[DQ_W-1] ? DQ_W'(-detq_reg) : DQ_W'(detq_reg);
        sing_next = dq_mag <= {{(DQ_W-mi3_pkg::THR_W){1'b0}}, det_threshold};
        dq_hi     = detq_reg[DQ_W-1:EW-1];
        dq_fits   = (&dq_hi) | (~|dq_hi);
        if (dq_fits)
        begin
            dsat_next = mi3_pkg::elem_t'(detq_reg[EW-1:0]);
        end
        else
        begin
            dsat_next = detq_reg[DQ_W-1] ? mi3_pkg::ELEM_MIN : mi3_pkg::ELEM_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            detq_reg <= mi3_pkg::detq_t'((in_det + HALF) >>> (2 * mi3_pkg::FRAC_BITS));
            absd_reg <= in_det[mi3_pkg::DET_W-1] ? mi3_pkg::mag_t'(-in_det)
                                                 : mi3_pkg::mag_t'(in_det);
            for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
            begin
                absadj_reg[i] <= in_adj[i][mi3_pkg::ADJ_W-1] ? mi3_pkg::amag_t'(-in_adj[i])
                                                             : mi3_pkg::amag_t'(in_adj[i]);
                neg6_reg[i]   <= in_adj[i][mi3_pkg::ADJ_W-1] ^ in_det[mi3_pkg::DET_W-1];
                num_reg[i]    <= (mi3_pkg::mag_t'(absadj_reg[i]) << (2 * mi3_pkg::FRAC_BITS + 1))
                               + absd_reg;
            end
            sing_reg <= sing_next;
            dsat_reg <= dsat_next;
            neg7_reg <= neg6_reg;
            den_reg  <= absd_reg << 1;
        end
    end

    always_comb
    begin
        out_valid = vld_reg[1];
        out_sing  = sing_reg;
        out_det   = dsat_reg;
        out_neg   = neg7_reg;
        out_den   = den_reg;
        for (int i = 0; i < mi3_pkg::NUM_ELEM; i++)
        begin
            out_num[i] = num_reg[i];
        end
    end

endmodule

### rtl/mi3_div.sv
// Nine-lane restoring divider, one quotient bit per stage, then sign and saturation.
// Depends on mi3_pkg.
module mi3_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic                                  in_sing,
    input  mi3_pkg::elem_t                        in_det,
    input  logic          [mi3_pkg::NUM_ELEM-1:0] in_neg,
    input  mi3_pkg::mag_t [mi3_pkg::NUM_ELEM-1:0] in_num,
    input  mi3_pkg::mag_t                         in_den,
    output logic                                  out_valid,
    output mi3_pkg::result_t                      out_res
);

    localparam int QW = mi3_pkg::QUO_W;
    localparam int NL = mi3_pkg::NUM_ELEM;
    localparam int CW = mi3_pkg::CMP_W;
    localparam int EW = mi3_pkg::ELEM_W;
    localparam logic [QW-1:0] NEG_LIMIT = QW'(1) << (EW - 1);

    logic                          vld_reg  [QW];
    logic                          sing_reg [QW];
    mi3_pkg::elem_t                det_reg  [QW];
    logic [NL-1:0]                 neg_reg  [QW];
    mi3_pkg::mag_t                 den_reg  [QW];
    mi3_pkg::mag_t [NL-1:0]        rem_reg  [QW];
    logic [NL-1:0][QW-1:0]         quo_reg  [QW];

    logic                          res_vld_reg;
    mi3_pkg::result_t              res_reg;
    mi3_pkg::result_t              res_next;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic                   src_v;
        logic                   src_s;
        mi3_pkg::elem_t         src_d;
        logic [NL-1:0]          src_n;
        mi3_pkg::mag_t          src_b;
        mi3_pkg::mag_t [NL-1:0] src_r;
        logic [NL-1:0][QW-1:0]  src_q;
        logic [CW-1:0]          trial;
        logic [NL-1:0]          ge;
        mi3_pkg::mag_t [NL-1:0] rem_next;
        logic [NL-1:0][QW-1:0]  quo_next;

        if (s == 0)
        begin : g_first
            assign src_v = in_valid;
            assign src_s = in_sing;
            assign src_d = in_det;
            assign src_n = in_neg;
            assign src_b = in_den;
            assign src_r = in_num;
            assign src_q = '0;
        end
        else
        begin : g_next
            assign src_v = vld_reg[s-1];
            assign src_s = sing_reg[s-1];
            assign src_d = det_reg[s-1];
            assign src_n = neg_reg[s-1];
            assign src_b = den_reg[s-1];
            assign src_r = rem_reg[s-1];
            assign src_q = quo_reg[s-1];
        end

        assign trial = CW'(src_b) << (QW - 1 - s);

        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            logic [CW-1:0] rext;
            assign rext        = CW'(src_r[l]);
            assign ge[l]       = rext >= trial;
            assign rem_next[l] = ge[l] ? mi3_pkg::mag_t'(rext - trial) : src_r[l];
            assign quo_next[l] = {src_q[l][QW-2:0], ge[l]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sing_reg[s] <= src_s;
                det_reg[s]  <= src_d;
                neg_reg[s]  <= src_n;
                den_reg[s]  <= src_b;
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
            end
        end
    end

    always_comb
    begin
        res_next.det  = det_reg[QW-1];
        res_next.sing = sing_reg[QW-1];
        for (int l = 0; l < NL; l++)
        begin
            if (sing_reg[QW-1])
            begin
                res_next.r[l] = '0;
            end
            else if (!neg_reg[QW-1][l])
            begin
                res_next.r[l] = (|quo_reg[QW-1][l][QW-1:EW-1]) ? mi3_pkg::ELEM_MAX
                              : mi3_pkg::elem_t'(quo_reg[QW-1][l][EW-1:0]);
            end
            else
            begin
                res_next.r[l] = (quo_reg[QW-1][l] > NEG_LIMIT) ? mi3_pkg::ELEM_MIN
                              : mi3_pkg::elem_t'(-quo_reg[QW-1][l][EW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            res_vld_reg <= vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_res   = res_reg;

endmodule

### rtl/matrix3_inverse_top.sv
// Top level of the 3x3 matrix inverse: APB threshold register, pipeline, output skid.
// Depends on mi3_pkg, mi3_adj, mi3_det, mi3_prep, mi3_div.
//
// Usage:
//   Input channel in_valid/in_ready carries one matrix a11..a33 (signed Q16.16) per beat.
//   Output channel out_valid/out_ready carries r11..r33, determinant and singular.
//   det_threshold sits at APB byte address 0; write it only while the block is idle.
//   A matrix whose rounded |determinant| is at or below det_threshold gives
//   singular = 1 and all-zero r fields; determinant is still reported.
//   Depth: 42 register stages. Throughput: one matrix per cycle while in_ready
//   is high. The depth comes from the 33-stage bit-per-stage divider that
//   follows 7 multiply/add stages.
//   Stall: the output has a main register plus one skid entry. When the skid
//   entry fills, in_ready drops and the whole pipeline holds; nothing is lost.
//   in_ready is a register output and does not depend on out_ready in the same cycle.
//   Reset: rst_n is asynchronous, active low; it empties the pipeline and
//   clears det_threshold to 0.
module matrix3_inverse_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mi3_pkg::ADDR_W-1:0]    paddr,
    input  logic [mi3_pkg::DATA_W-1:0]    pwdata,
    output logic [mi3_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mi3_pkg::elem_t                a11,
    input  mi3_pkg::elem_t                a12,
    input  mi3_pkg::elem_t                a13,
    input  mi3_pkg::elem_t                a21,
    input  mi3_pkg::elem_t                a22,
    input  mi3_pkg::elem_t                a23,
    input  mi3_pkg::elem_t                a31,
    input  mi3_pkg::elem_t                a32,
    input  mi3_pkg::elem_t                a33,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mi3_pkg::elem_t                r11,
    output mi3_pkg::elem_t                r12,
    output mi3_pkg::elem_t                r13,
    output mi3_pkg::elem_t                r21,
    output mi3_pkg::elem_t                r22,
    output mi3_pkg::elem_t                r23,
    output mi3_pkg::elem_t                r31,
    output mi3_pkg::elem_t                r32,
    output mi3_pkg::elem_t                r33,
    output mi3_pkg::elem_t                determinant,
    output logic                          singular
);

    localparam int NL = mi3_pkg::NUM_ELEM;

    mi3_pkg::thr_t thr_reg;
    logic          en;

    mi3_pkg::elem_t [NL-1:0] elem;
    logic                    adj_v;
    mi3_pkg::adj_t  [NL-1:0] adj_a;
    mi3_pkg::elem_t [2:0]    adj_row1;
    logic                    det_v;
    mi3_pkg::adj_t  [NL-1:0] det_adj;
    mi3_pkg::det_t           det_d;
    logic                    prep_v;
    logic                    prep_sing;
    mi3_pkg::elem_t          prep_det;
    logic [NL-1:0]           prep_neg;
    mi3_pkg::mag_t  [NL-1:0] prep_num;
    mi3_pkg::mag_t           prep_den;
    logic                    div_v;
    mi3_pkg::result_t        div_res;

    logic             out_vld_reg;
    mi3_pkg::result_t out_reg;
    logic             skid_full_reg;
    mi3_pkg::result_t skid_reg;
    logic             push;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == mi3_pkg::REG_DET_THRESHOLD))
        begin
            thr_reg <= pwdata[mi3_pkg::THR_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == mi3_pkg::REG_DET_THRESHOLD)
        begin
            prdata = {{(mi3_pkg::DATA_W-mi3_pkg::THR_W){1'b0}}, thr_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // pipeline
    assign en       = !skid_full_reg;
    assign in_ready = en;
    assign elem     = {a33, a32, a31, a23, a22, a21, a13, a12, a11};

    mi3_adj u_adj (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_elem   (elem),
        .out_valid (adj_v),
        .out_adj   (adj_a),
        .out_row1  (adj_row1)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adj_v),
        .in_adj    (adj_a),
        .in_row1   (adj_row1),
        .out_valid (det_v),
        .out_adj   (det_adj),
        .out_det   (det_d)
    );

    mi3_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (det_v),
        .in_adj        (det_adj),
        .in_det        (det_d),
        .det_threshold (thr_reg),
        .out_valid     (prep_v),
        .out_sing      (prep_sing),
        .out_det       (prep_det),
        .out_neg       (prep_neg),
        .out_num       (prep_num),
        .out_den       (prep_den)
    );

    mi3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_v),
        .in_sing   (prep_sing),
        .in_det    (prep_det),
        .in_neg    (prep_neg),
        .in_num    (prep_num),
        .in_den    (prep_den),
        .out_valid (div_v),
        .out_res   (div_res)
    );

    // output register with one skid entry
    assign push = en && div_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            if (skid_full_reg)
            begin
                out_vld_reg   <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            out_reg <= skid_full_reg ? skid_reg : div_res;
        end
        else if (push)
        begin
            skid_reg <= div_res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign r11         = out_reg.r[0];
    assign r12         = out_reg.r[1];
    assign r13         = out_reg.r[2];
    assign r21         = out_reg.r[3];
    assign r22         = out_reg.r[4];
    assign r23         = out_reg.r[5];
    assign r31         = out_reg.r[6];
    assign r32         = out_reg.r[7];
    assign r33         = out_reg.r[8];
    assign determinant = out_reg.det;
    assign singular    = out_reg.sing;

endmodule
